// ----- rtl/cdd_pkg.sv -----
// shared types, constants and helper functions for the calendar date difference block
// no dependencies; imported by cdd_date_check, calendar_date_difference and the tb

package cdd_pkg;

    // field widths of one date, of a month length and of year / 100
    localparam int DAY_W   = 7;
    localparam int MONTH_W = 7;
    localparam int YEAR_W  = 14;
    localparam int LEN_W   = 5;
    localparam int QUOT_W  = 8;

    // result field widths
    localparam int DIFF_YEARS_W  = 14;
    localparam int DIFF_MONTHS_W = 4;
    localparam int DIFF_DAYS_W   = 6;

    // two-digit year window
    localparam logic [YEAR_W-1:0] TWO_DIGIT_LIMIT = 14'd100;
    localparam logic [YEAR_W-1:0] WINDOW_PIVOT    = 14'd49;
    localparam logic [YEAR_W-1:0] BASE_2000       = 14'd2000;
    localparam logic [YEAR_W-1:0] BASE_1900       = 14'd1900;

    // divide by 100 through a reciprocal: q = (y * 5243) >> 19, exact for y < 16384
    localparam int                RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
    localparam int                RECIP_SHIFT = 19;
    localparam int                PROD_W      = YEAR_W + RECIP_W;
    localparam logic [YEAR_W:0]   CENTURY     = 15'd100;

    // months
    localparam logic [3:0]       MONTH_JAN    = 4'd1;
    localparam logic [3:0]       MONTH_FEB    = 4'd2;
    localparam logic [3:0]       MONTH_DEC    = 4'd12;
    localparam logic [LEN_W-1:0] LONG_MONTH   = 5'd31;
    localparam logic [4:0]       MONTHS_IN_YR = 5'd12;

    localparam logic [LEN_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_START_BAD = 2'd1,
        STATUS_END_BAD   = 2'd2,
        STATUS_ORDER     = 2'd3
    } status_t;

    // one split date
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               well_formed;
    } date_t;

    // map a two-digit year into 1950..2049
    function automatic logic [YEAR_W-1:0] window_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] w;
        if (y < TWO_DIGIT_LIMIT) begin
            w = y + ((y <= WINDOW_PIVOT) ? BASE_2000 : BASE_1900);
        end else begin
            w = y;
        end
        return w;
    endfunction

    // days in a month 1..12 with leap february; other codes give 31
    function automatic logic [LEN_W-1:0] month_len(input logic [3:0] m, input logic leap);
        logic [LEN_W-1:0] d;
        if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            d = MONTH_LEN[m - MONTH_JAN];
        end else begin
            d = LONG_MONTH;
        end
        if (m == MONTH_FEB && leap) begin
            d = d + 5'd1;
        end
        return d;
    endfunction

endpackage

// ----- rtl/calendar_date_difference.sv -----
// top level of the calendar date difference block: five-stage stream pipeline
// depends on cdd_pkg and cdd_date_check

// Takes one pair of split dates per item and returns one result item: a status
// (ok, first date invalid, second date invalid, first after second) and the gap
// in whole years, remaining months and remaining days. Two-digit years map to
// 1950..2049. The day borrow uses the length of the month before the end month,
// so the day count can reach -2. One item is accepted every clock cycle unless
// the output stalls; each item passes the window, divide by 100, date check,
// compare and subtract, borrow and output register stages. Every stage holds its
// item while the next one is full and stalled, and empty stages fill up behind it.

module calendar_date_difference
    import cdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // start_day, start_month, start_year, end_day, end_month, end_year
    input  logic [55:0] s_tdata,
    // start_well_formed, end_well_formed
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,

    // diff_years, diff_months, diff_days
    output logic [23:0] m_tdata,
    // status
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);

    // stage valids and stall chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

    assign s5_ready = !s5_valid_reg || m_tready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= s_tvalid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: unpack and window two-digit years
    date_t s1_start_next, s1_end_next;
    date_t s1_start_reg, s1_end_reg;

    always_comb begin
        s1_start_next.day         = s_tdata[6:0];
        s1_start_next.month       = s_tdata[13:7];
        s1_start_next.year        = window_year(s_tdata[27:14]);
        s1_start_next.well_formed = s_tuser[0];
        s1_end_next.day           = s_tdata[34:28];
        s1_end_next.month         = s_tdata[41:35];
        s1_end_next.year          = window_year(s_tdata[55:42]);
        s1_end_next.well_formed   = s_tuser[1];
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_start_reg <= s1_start_next;
            s1_end_reg   <= s1_end_next;
        end
    end

    // stage 2: year / 100 by reciprocal multiply
    logic [PROD_W-1:0] s2_start_prod, s2_end_prod;
    logic [QUOT_W-1:0] s2_start_q_next, s2_end_q_next;
    logic [QUOT_W-1:0] s2_start_q_reg, s2_end_q_reg;
    date_t             s2_start_reg, s2_end_reg;

    assign s2_start_prod   = {{RECIP_W{1'b0}}, s1_start_reg.year} * {{YEAR_W{1'b0}}, RECIP_100};
    assign s2_end_prod     = {{RECIP_W{1'b0}}, s1_end_reg.year} * {{YEAR_W{1'b0}}, RECIP_100};
    assign s2_start_q_next = s2_start_prod[RECIP_SHIFT +: QUOT_W];
    assign s2_end_q_next   = s2_end_prod[RECIP_SHIFT +: QUOT_W];

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_start_reg   <= s1_start_reg;
            s2_end_reg     <= s1_end_reg;
            s2_start_q_reg <= s2_start_q_next;
            s2_end_q_reg   <= s2_end_q_next;
        end
    end

    // stage 3: leap years, date checks, length of the month before the end month
    logic             s3_start_leap, s3_end_leap;
    logic [LEN_W-1:0] s3_start_len, s3_end_len;
    logic             s3_start_ok_next, s3_end_ok_next;
    logic [LEN_W-1:0] s3_prev_len_next;
    logic             s3_start_ok_reg, s3_end_ok_reg;
    logic [LEN_W-1:0] s3_prev_len_reg;
    date_t            s3_start_reg, s3_end_reg;

    cdd_date_check u_start_check (
        .date   (s2_start_reg),
        .year_q (s2_start_q_reg),
        .leap   (s3_start_leap),
        .len    (s3_start_len),
        .ok     (s3_start_ok_next)
    );

    cdd_date_check u_end_check (
        .date   (s2_end_reg),
        .year_q (s2_end_q_reg),
        .leap   (s3_end_leap),
        .len    (s3_end_len),
        .ok     (s3_end_ok_next)
    );

    // january borrows from december; march borrows february of the same year
    assign s3_prev_len_next = (s2_end_reg.month[3:0] == MONTH_JAN) ? LONG_MONTH :
                              month_len(s2_end_reg.month[3:0] - 4'd1, s3_end_leap);

    always_ff @(posedge aclk) begin
        if (s3_ready) begin
            s3_start_reg    <= s2_start_reg;
            s3_end_reg      <= s2_end_reg;
            s3_start_ok_reg <= s3_start_ok_next;
            s3_end_ok_reg   <= s3_end_ok_next;
            s3_prev_len_reg <= s3_prev_len_next;
        end
    end

    // stage 4: status and raw differences
    status_t                  s4_status_next, s4_status_reg;
    logic                     s4_after;
    logic [DIFF_YEARS_W-1:0]  s4_years_next, s4_years_reg;
    logic signed [4:0]        s4_months_next, s4_months_reg;
    logic signed [5:0]        s4_days_next, s4_days_reg;
    logic [LEN_W-1:0]         s4_prev_len_reg;

    assign s4_after = (s3_end_reg.year < s3_start_reg.year) ||
                      ((s3_end_reg.year == s3_start_reg.year) &&
                       (s3_end_reg.month < s3_start_reg.month)) ||
                      ((s3_end_reg.year == s3_start_reg.year) &&
                       (s3_end_reg.month == s3_start_reg.month) &&
                       (s3_end_reg.day < s3_start_reg.day));

    always_comb begin
        priority if (!s3_start_ok_reg) begin
            s4_status_next = STATUS_START_BAD;
        end else if (!s3_end_ok_reg) begin
            s4_status_next = STATUS_END_BAD;
        end else if (s4_after) begin
            s4_status_next = STATUS_ORDER;
        end else begin
            s4_status_next = STATUS_OK;
        end
    end

    // valid dates keep months in 1..12 and days in 1..31
    assign s4_years_next  = s3_end_reg.year - s3_start_reg.year;
    assign s4_months_next = $signed({1'b0, s3_end_reg.month[3:0]}) -
                            $signed({1'b0, s3_start_reg.month[3:0]});
    assign s4_days_next   = $signed({1'b0, s3_end_reg.day[4:0]}) -
                            $signed({1'b0, s3_start_reg.day[4:0]});

    always_ff @(posedge aclk) begin
        if (s4_ready) begin
            s4_status_reg   <= s4_status_next;
            s4_years_reg    <= s4_years_next;
            s4_months_reg   <= s4_months_next;
            s4_days_reg     <= s4_days_next;
            s4_prev_len_reg <= s3_prev_len_reg;
        end
    end

    // stage 5: day and month borrows, zero unless ok, output register
    logic                     s5_borrow;
    logic signed [6:0]        s5_days_sum;
    logic signed [4:0]        s5_months_adj;
    logic [4:0]               s5_months_wrap;
    logic [DIFF_YEARS_W-1:0]  s5_years_next, s5_years_reg;
    logic [DIFF_MONTHS_W-1:0] s5_months_next, s5_months_reg;
    logic [DIFF_DAYS_W-1:0]   s5_days_next, s5_days_reg;
    status_t                  s5_status_reg;

    assign s5_borrow      = s4_days_reg[5];
    assign s5_days_sum    = s5_borrow ?
                            (7'(s4_days_reg) + $signed({2'b00, s4_prev_len_reg})) :
                            7'(s4_days_reg);
    assign s5_months_adj  = s4_months_reg - $signed({4'b0000, s5_borrow});
    assign s5_months_wrap = 5'(s5_months_adj) + MONTHS_IN_YR;

    always_comb begin
        if (s4_status_reg != STATUS_OK) begin
            s5_years_next  = '0;
            s5_months_next = '0;
            s5_days_next   = '0;
        end else if (s5_months_adj[4]) begin
            s5_years_next  = s4_years_reg - 14'd1;
            s5_months_next = s5_months_wrap[3:0];
            s5_days_next   = s5_days_sum[5:0];
        end else begin
            s5_years_next  = s4_years_reg;
            s5_months_next = s5_months_adj[3:0];
            s5_days_next   = s5_days_sum[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready) begin
            s5_status_reg <= s4_status_reg;
            s5_years_reg  <= s5_years_next;
            s5_months_reg <= s5_months_next;
            s5_days_reg   <= s5_days_next;
        end
    end

    // result channel
    assign m_tvalid = s5_valid_reg;
    assign m_tuser  = s5_status_reg;
    assign m_tdata  = {s5_days_reg, s5_months_reg, s5_years_reg};

endmodule

// ----- rtl/cdd_date_check.sv -----
// leap year and validity check of one windowed date
// depends on cdd_pkg (date_t, month_len, CENTURY)

module cdd_date_check
    import cdd_pkg::*;
(
    input  date_t             date,     // year already windowed
    input  logic [QUOT_W-1:0] year_q,   // year / 100
    output logic              leap,
    output logic [LEN_W-1:0]  len,      // days in this date's month
    output logic              ok
);

    logic [YEAR_W:0] century_part;
    logic            century_year;
    logic            month_ok;
    logic            day_ok;

    // leap rule: by 4, not by 100 unless by 400 (year / 100 divisible by 4)
    assign century_part = {{(YEAR_W+1-QUOT_W){1'b0}}, year_q} * CENTURY;
    assign century_year = (date.year == century_part[YEAR_W-1:0]);
    assign leap = century_year ? (year_q[1:0] == 2'b00) : (date.year[1:0] == 2'b00);

    // month and day range
    assign len      = month_len(date.month[3:0], leap);
    assign month_ok = (date.month >= 7'(MONTH_JAN)) && (date.month <= 7'(MONTH_DEC));
    assign day_ok   = (date.day != '0) && (date.day <= {2'b00, len});
    assign ok       = date.well_formed && month_ok && day_ok;

endmodule

// ----- dv/calendar_date_difference_tb.sv -----
// testbench for calendar_date_difference: random and directed date pairs on the input
// stream, results checked field by field against an in-file date gap predictor
// depends on cdd_pkg and the calendar_date_difference rtl
`timescale 1ns / 1ps

module calendar_date_difference_tb;
    import cdd_pkg::*;

    localparam int N_ITEMS    = 1850;
    localparam int DRAIN_WAIT = 20;
    localparam int DATE_W     = $bits(date_t);

    // expected result of one date pair
    typedef struct packed {
        status_t            status;
        logic [13:0]        years;
        logic [3:0]         months;
        logic signed [5:0]  days;
    } gap_t;

    typedef struct packed {
        date_t first;
        date_t second;
    } date_pair_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    date_pair_t pending_pairs[$];
    gap_t       expected_gaps[$];

    logic s_took = 1'b0;
    int   tx_cycle = 0;
    int   rx_cycle = 0;
    int   hold_left = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_errors = 0;
    int   status_seen[4];
    int   n_neg_days = 0;

    calendar_date_difference u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // two-digit years fold into 1950..2049
    function automatic int unsigned full_year(input logic [13:0] y);
        if (y < 100) begin
            return (y <= 49) ? y + 2000 : y + 1900;
        end
        return y;
    endfunction

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        case (m)
            2: begin
                return leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                return 30;
            end
            default: begin
                return 31;
            end
        endcase
    endfunction

    function automatic bit date_valid(input date_t d, input int unsigned y);
        return d.well_formed && d.month >= 1 && d.month <= 12 && d.day >= 1
            && d.day <= days_in_month(d.month, y);
    endfunction

    // status and gap in years, months and days for one pair
    function automatic gap_t predict_gap(input date_pair_t p);
        gap_t        g;
        int unsigned sy, ey, pm, py;
        int          yrs, mos, dys;
        g = '0;
        g.status = STATUS_OK;
        sy = full_year(p.first.year);
        ey = full_year(p.second.year);
        if (!date_valid(p.first, sy)) begin
            g.status = STATUS_START_BAD;
        end else if (!date_valid(p.second, ey)) begin
            g.status = STATUS_END_BAD;
        end else if (ey < sy || (ey == sy && p.second.month < p.first.month)
                || (ey == sy && p.second.month == p.first.month
                    && p.second.day < p.first.day)) begin
            g.status = STATUS_ORDER;
        end else begin
            yrs = int'(ey) - int'(sy);
            mos = int'(p.second.month) - int'(p.first.month);
            dys = int'(p.second.day) - int'(p.first.day);
            // borrow the length of the month before the end month
            if (dys < 0) begin
                pm = p.second.month - 1;
                py = ey;
                mos = mos - 1;
                if (pm == 0) begin
                    pm = 12;
                    py = py - 1;
                end
                dys = dys + int'(days_in_month(pm, py));
            end
            if (mos < 0) begin
                yrs = yrs - 1;
                mos = mos + 12;
            end
            g.years  = yrs[13:0];
            g.months = mos[3:0];
            g.days   = dys[5:0];
        end
        return g;
    endfunction

    // random valid date, biased toward month edges and century years
    task automatic pick_date(output logic [6:0] d, output logic [6:0] m,
                             output logic [13:0] y);
        int unsigned len;
        case ($urandom_range(0, 3))
            0: y = 14'($urandom_range(0, 99));
            1: y = 14'($urandom_range(1890, 2110));
            2: y = 14'($urandom_range(100, 16383));
            default: y = 14'($urandom_range(1, 163) * 100);
        endcase
        m = 7'($urandom_range(1, 12));
        len = days_in_month(m, full_year(y));
        case ($urandom_range(0, 2))
            0: d = 7'($urandom_range(len - 2, len));
            1: d = 7'($urandom_range(1, 3));
            default: d = 7'($urandom_range(1, len));
        endcase
    endtask

    task automatic add_pair(input int sd, input int sm, input int sy, input bit sw,
                            input int ed, input int em, input int ey, input bit ew);
        date_pair_t p;
        p.first  = '{day: 7'(sd), month: 7'(sm), year: 14'(sy), well_formed: sw};
        p.second = '{day: 7'(ed), month: 7'(em), year: 14'(ey), well_formed: ew};
        pending_pairs.push_back(p);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        n_errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endtask

    // sender: holds an item until taken, otherwise may idle
    always @(negedge aclk) begin : sender
        date_pair_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_cycle <= 0;
        end else begin
            tx_cycle <= tx_cycle + 1;
            if (!s_tvalid || s_took) begin
                if (pending_pairs.size() > 0
                        && ((tx_cycle >= 300 && tx_cycle < 700)
                            || $urandom_range(0, 99) >= 25)) begin
                    nxt = pending_pairs.pop_front();
                    s_tdata  <= {nxt.second.year, nxt.second.month, nxt.second.day,
                                 nxt.first.year, nxt.first.month, nxt.first.day};
                    s_tuser  <= {nxt.second.well_formed, nxt.first.well_formed};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold-off, a quiet stretch, random stalls elsewhere
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle == 400) begin
                hold_left <= 80;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (rx_cycle >= 1500 && rx_cycle < 2300) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // monitor: predict on input items, check result items in order
    always @(posedge aclk) begin : monitor
        date_pair_t seen;
        gap_t       want;
        if (!aresetn) begin
            s_took <= 1'b0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                seen.first  = '{day: s_tdata[6:0], month: s_tdata[13:7],
                                year: s_tdata[27:14], well_formed: s_tuser[0]};
                seen.second = '{day: s_tdata[34:28], month: s_tdata[41:35],
                                year: s_tdata[55:42], well_formed: s_tuser[1]};
                expected_gaps.push_back(predict_gap(seen));
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_gaps.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none actual status %0d",
                             $time, m_tuser);
                end else begin
                    want = expected_gaps.pop_front();
                    n_results++;
                    status_seen[want.status]++;
                    if (want.days < 0) n_neg_days++;
                    if (m_tuser != want.status)
                        report_field("status", want.status, m_tuser);
                    if (m_tdata[13:0] != want.years)
                        report_field("diff_years", want.years, m_tdata[13:0]);
                    if (m_tdata[17:14] != want.months)
                        report_field("diff_months", want.months, m_tdata[17:14]);
                    if (m_tdata[23:18] != want.days)
                        report_field("diff_days", want.days,
                                     $signed(m_tdata[23:18]));
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        date_pair_t  p;
        date_t       tmp;
        logic [13:0] spare_year;
        int          r, total;
        int unsigned fa, fb;

        // directed: equal dates, borrows, leap rules, bad dates, ordering, extremes
        add_pair(1, 1, 2000, 1, 1, 1, 2000, 1);
        add_pair(31, 1, 2023, 1, 1, 3, 2023, 1);
        add_pair(31, 1, 2024, 1, 1, 3, 2024, 1);
        add_pair(15, 12, 2023, 1, 10, 1, 2024, 1);
        add_pair(31, 3, 2023, 1, 1, 5, 2023, 1);
        add_pair(29, 2, 2000, 1, 1, 3, 2000, 1);
        add_pair(29, 2, 1900, 1, 1, 3, 1900, 1);
        add_pair(1, 1, 2000, 1, 29, 2, 2100, 1);
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(5, 5, 2010, 0, 6, 6, 2011, 1);
        add_pair(5, 5, 2010, 1, 6, 6, 2011, 0);
        add_pair(1, 13, 2010, 1, 1, 0, 2011, 1);
        add_pair(1, 1, 2010, 1, 1, 0, 2011, 1);
        add_pair(32, 1, 2010, 1, 1, 2, 2011, 1);
        add_pair(1, 1, 2010, 1, 0, 2, 2011, 1);
        add_pair(2, 1, 2020, 1, 1, 1, 2020, 1);
        add_pair(1, 1, 2021, 1, 31, 12, 2020, 1);
        add_pair(1, 2, 2020, 1, 1, 1, 2020, 1);
        add_pair(1, 1, 50, 1, 1, 1, 49, 1);
        add_pair(31, 12, 99, 1, 1, 1, 0, 1);
        add_pair(31, 12, 100, 1, 31, 12, 16383, 1);
        add_pair(127, 127, 16383, 1, 127, 127, 16383, 1);
        add_pair(1, 1, 2023, 1, 31, 1, 2023, 1);
        add_pair(1, 1, 2023, 1, 31, 12, 2023, 1);

        // random: mostly valid pairs, some broken, some raw noise
        repeat (N_ITEMS - pending_pairs.size()) begin
            r = $urandom_range(0, 99);
            pick_date(p.first.day, p.first.month, p.first.year);
            p.first.well_formed = 1'b1;
            pick_date(p.second.day, p.second.month, spare_year);
            p.second.well_formed = 1'b1;
            if ($urandom_range(0, 1)) begin
                p.second.year = spare_year;
            end else begin
                p.second.year = p.first.year + 14'($urandom_range(0, 2));
                if (p.second.month == 2 && p.second.day == 29) p.second.day = 7'd28;
            end
            if (r < 70) begin
                fa = full_year(p.first.year);
                fb = full_year(p.second.year);
                if ({fa, p.first.month, p.first.day} > {fb, p.second.month, p.second.day}
                        && $urandom_range(0, 9) != 0) begin
                    tmp = p.first;
                    p.first = p.second;
                    p.second = tmp;
                end
            end else if (r < 85) begin
                case ($urandom_range(0, 5))
                    0: p.first.well_formed = 1'b0;
                    1: p.second.well_formed = 1'b0;
                    2: p.first.month = $urandom_range(0, 1) ? 7'd0 :
                           7'($urandom_range(13, 127));
                    3: p.second.day = $urandom_range(0, 1) ? 7'd0 :
                           7'(days_in_month(p.second.month, full_year(p.second.year))
                              + $urandom_range(1, 3));
                    4: p.first.day = $urandom_range(0, 1) ? 7'd0 :
                           7'($urandom_range(32, 127));
                    default: begin
                        p.first.well_formed  = 1'b0;
                        p.second.well_formed = 1'b0;
                    end
                endcase
            end else begin
                p.first  = DATE_W'($urandom);
                p.second = DATE_W'($urandom);
            end
            pending_pairs.push_back(p);
        end
        total = pending_pairs.size();

        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (n_accepted < total) @(posedge aclk);
        while (expected_gaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("%0d date pairs sent, %0d results checked", n_accepted, n_results);
        $display("status ok %0d, start bad %0d, end bad %0d, out of order %0d, negative days %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], n_neg_days);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
